FILE: src/utdt_pkg.sv
// package for the timer driven uart transceiver
// shared widths, reset constants, status structs and the countdown step
// no dependencies
package utdt_pkg;

  localparam int BYTE_W        = 8;
  localparam int CNT_W         = 16;
  localparam int DATA_BITS_DEF = 8;

  localparam logic [CNT_W-1:0] BIT_PERIOD_RST = CNT_W'(138);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic level;
    logic active;
  } tx_stat_t;

  typedef struct packed {
    logic  valid;
    byte_t data;
  } rx_stat_t;

  typedef struct packed {
    logic expire;
    cnt_t cnt;
  } tick_t;

  // one step of a bit countdown, reloads with the period on expiry
  function automatic tick_t tick_step(cnt_t cnt, cnt_t period);
    tick_t t;
    if (cnt <= CNT_W'(1)) begin
      t.expire = 1'b1;
      t.cnt    = period;
    end else begin
      t.expire = 1'b0;
      t.cnt    = cnt - CNT_W'(1);
    end
    return t;
  endfunction

endpackage

FILE: src/utdt_if.sv
// valid/ready channel interfaces for the uart transceiver
// depends on utdt_pkg
interface utdt_in_if;
  import utdt_pkg::*;
  logic  valid;
  logic  ready;
  logic  tx_start;
  byte_t tx_byte;
  logic  rx_pin;
  modport source (output valid, tx_start, tx_byte, rx_pin, input ready);
  modport sink (input valid, tx_start, tx_byte, rx_pin, output ready);
endinterface

interface utdt_out_if;
  import utdt_pkg::*;
  logic  valid;
  logic  ready;
  logic  tx_pin;
  logic  tx_busy;
  logic  rx_valid;
  byte_t rx_byte;
  modport source (output valid, tx_pin, tx_busy, rx_valid, rx_byte, input ready);
  modport sink (input valid, tx_pin, tx_busy, rx_valid, rx_byte, output ready);
endinterface

interface utdt_cfg_if;
  import utdt_pkg::*;
  logic valid;
  logic ready;
  cnt_t bit_period;
  modport source (output valid, bit_period, input ready);
  modport sink (input valid, bit_period, output ready);
endinterface

FILE: src/utdt_tx.sv
// uart transmitter state, one frame bit per bit period
// depends on utdt_pkg
module utdt_tx #(
  parameter int DATA_BITS = utdt_pkg::DATA_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               tx_start,
  input  utdt_pkg::byte_t    tx_byte,
  input  utdt_pkg::cnt_t     bit_period,
  output utdt_pkg::tx_stat_t stat
);
  import utdt_pkg::*;

  localparam int FRAME_W = DATA_BITS + 2;
  localparam int LEFT_W  = $clog2(DATA_BITS + 3);

  logic [FRAME_W-1:0]          frame_r, frame_nxt;
  logic [LEFT_W-1:0]           left_r, left_nxt;
  cnt_t                        cnt_r, cnt_nxt;
  logic                        active_r, active_nxt;
  logic                        level_r, level_nxt;
  logic [DATA_BITS+BYTE_W-1:0] byte_ext;
  tick_t                       tk;

  assign byte_ext = {DATA_BITS'(0), tx_byte};
  assign tk       = tick_step(cnt_r, bit_period);

  always_comb begin
    frame_nxt  = frame_r;
    left_nxt   = left_r;
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    level_nxt  = level_r;
    if (active_r) begin
      cnt_nxt = tk.cnt;
      if (tk.expire) begin
        if (left_r == '0) begin
          active_nxt = 1'b0;
          left_nxt   = LEFT_W'(DATA_BITS + 2);
        end else begin
          level_nxt = frame_r[0];
          frame_nxt = frame_r >> 1;
          left_nxt  = left_r - LEFT_W'(1);
        end
      end
    end else if (tx_start) begin
      frame_nxt  = {1'b1, byte_ext[DATA_BITS-1:0], 1'b0};
      left_nxt   = LEFT_W'(DATA_BITS + 2);
      cnt_nxt    = bit_period;
      active_nxt = 1'b1;
      level_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r  <= '0;
      left_r   <= LEFT_W'(DATA_BITS + 2);
      cnt_r    <= '0;
      active_r <= 1'b0;
      level_r  <= 1'b1;
    end else if (step) begin
      frame_r  <= frame_nxt;
      left_r   <= left_nxt;
      cnt_r    <= cnt_nxt;
      active_r <= active_nxt;
      level_r  <= level_nxt;
    end
  end

  assign stat.level  = level_nxt;
  assign stat.active = active_nxt;

endmodule

FILE: src/utdt_rx.sv
// uart receiver state, edge hunt then mid-bit sampling
// depends on utdt_pkg
module utdt_rx #(
  parameter int DATA_BITS = utdt_pkg::DATA_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               rx_pin,
  input  utdt_pkg::cnt_t     bit_period,
  output utdt_pkg::rx_stat_t stat
);
  import utdt_pkg::*;

  localparam int LEFT_W = $clog2(DATA_BITS + 3);

  cnt_t                        cnt_r, cnt_nxt;
  logic                        hunt_r, hunt_nxt;
  logic [DATA_BITS-1:0]        shift_r, shift_nxt;
  logic [LEFT_W-1:0]           left_r, left_nxt;
  logic                        last_r;
  logic [DATA_BITS-1:0]        held_r, held_nxt;
  logic                        valid;
  logic [DATA_BITS+BYTE_W-1:0] held_ext;
  tick_t                       tk;

  assign tk = tick_step(cnt_r, bit_period);

  always_comb begin
    cnt_nxt   = cnt_r;
    hunt_nxt  = hunt_r;
    shift_nxt = shift_r;
    left_nxt  = left_r;
    held_nxt  = held_r;
    valid     = 1'b0;
    if (hunt_r) begin
      if (last_r && !rx_pin) begin
        hunt_nxt = 1'b0;
        cnt_nxt  = bit_period >> 1;
        left_nxt = LEFT_W'(DATA_BITS + 1);
      end
    end else begin
      cnt_nxt = tk.cnt;
      if (tk.expire) begin
        if (left_r > LEFT_W'(DATA_BITS)) begin
          left_nxt = LEFT_W'(DATA_BITS);
        end else begin
          shift_nxt = {rx_pin, shift_r[DATA_BITS-1:1]};
          if (left_r <= LEFT_W'(1)) begin
            held_nxt = shift_nxt;
            valid    = 1'b1;
            left_nxt = LEFT_W'(DATA_BITS);
            hunt_nxt = 1'b1;
          end else begin
            left_nxt = left_r - LEFT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      hunt_r  <= 1'b1;
      shift_r <= '0;
      left_r  <= LEFT_W'(DATA_BITS);
      last_r  <= 1'b1;
      held_r  <= '0;
    end else if (step) begin
      cnt_r   <= cnt_nxt;
      hunt_r  <= hunt_nxt;
      shift_r <= shift_nxt;
      left_r  <= left_nxt;
      last_r  <= rx_pin;
      held_r  <= held_nxt;
    end
  end

  assign held_ext   = {BYTE_W'(0), held_nxt};
  assign stat.valid = valid;
  assign stat.data  = held_ext[BYTE_W-1:0];

endmodule

FILE: src/timer_driven_uart_transceiver.sv
// timer driven 8N1 uart transceiver, top level
// depends on utdt_pkg, utdt_if, utdt_tx and utdt_rx
//
// each input beat is one uart clock tick: a send request with its byte and the
// sampled receive pin; each input beat yields exactly one output beat with the
// transmit pin, the busy flag, the receive valid pulse and the last byte
// the input beat lands in an input register, the tx and rx state advance as it
// moves into the output register; the output beat is presented from that
// register and taken when out_ch.ready is high, so each beat passes the input
// and then the output register; throughput one beat per cycle unless stalled
// when the output side stalls the output register holds its beat, the input
// register holds the next one, and in_ch.ready drops only if both are full
// the cfg channel writes bit_period (input beats per bit), always ready; write it
// only while no beats are in flight
// reset (rst_n low, synchronous) empties both registers, sets bit_period to
// 138, idles the transmitter at mark and arms the receiver for a start edge
module timer_driven_uart_transceiver #(
  parameter int DATA_BITS = utdt_pkg::DATA_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  utdt_in_if.sink   in_ch,
  utdt_out_if.source out_ch,
  utdt_cfg_if.sink  cfg_ch
);
  import utdt_pkg::*;

  cnt_t     bit_period_r;
  logic     in_valid_r;
  logic     in_start_r;
  byte_t    in_byte_r;
  logic     in_pin_r;
  logic     out_valid_r;
  logic     out_pin_r;
  logic     out_busy_r;
  logic     out_rxv_r;
  byte_t    out_byte_r;
  logic     adv;
  tx_stat_t tx_stat;
  rx_stat_t rx_stat;

  assign adv          = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || adv;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= BIT_PERIOD_RST;
    end else if (cfg_ch.valid) begin
      bit_period_r <= cfg_ch.bit_period;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_start_r <= in_ch.tx_start;
      in_byte_r  <= in_ch.tx_byte;
      in_pin_r   <= in_ch.rx_pin;
    end
  end

  utdt_tx #(.DATA_BITS(DATA_BITS)) u_tx (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .tx_start   (in_start_r),
    .tx_byte    (in_byte_r),
    .bit_period (bit_period_r),
    .stat       (tx_stat)
  );

  utdt_rx #(.DATA_BITS(DATA_BITS)) u_rx (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .rx_pin     (in_pin_r),
    .bit_period (bit_period_r),
    .stat       (rx_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pin_r  <= tx_stat.level;
      out_busy_r <= tx_stat.active;
      out_rxv_r  <= rx_stat.valid;
      out_byte_r <= rx_stat.data;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.tx_pin   = out_pin_r;
  assign out_ch.tx_busy  = out_busy_r;
  assign out_ch.rx_valid = out_rxv_r;
  assign out_ch.rx_byte  = out_byte_r;

`ifndef SYNTHESIS
  a_adv_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced beat did not reach the output register");

  a_idle_is_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_busy_r) |-> out_pin_r)
    else $error("transmit line not at mark while idle");

  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> (in_valid_r && $stable(in_byte_r) && $stable(in_pin_r)))
    else $error("stalled input beat lost or changed");
`endif

endmodule
